// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

  // Field and register widths fixed by the interface.
  localparam int RADIX_W = 9;
  localparam int DIGIT_W = 8;

  // Defaults for the top-level parameters.
  localparam int DEF_VALUE_BITS = 31;
  localparam int DEF_MAX_DIGITS = 31;

  // Radix register reset value and the legal radix range.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;

  // Classification of one queued request.
  typedef struct packed {
    logic               is_zero;
    logic [RADIX_W-1:0] radix;
  } rdc_cls_t;

  // Bring any register value into the range two to 256.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

endpackage

// ===== rtl/rdc_front.sv =====
module rdc_front import rdc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RADIX_W-1:0]    cfg_radix,
  output logic                  q_valid,
  output logic [VALUE_BITS-1:0] q_value,
  output rdc_cls_t              q_cls,
  input  logic                  q_pop
);

  logic [RADIX_W-1:0]    radix_r;
  logic [VALUE_BITS-1:0] val_mem_r [2];
  rdc_cls_t              cls_mem_r [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            count_r;
  logic [1:0]            count_nxt;
  logic                  push;
  rdc_cls_t              cls_in;

  // The radix register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_valid) begin
      radix_r <= cfg_radix;
    end
  end

  // Classify the incoming request: clamped radix and the zero special case.
  always_comb begin
    cls_in.is_zero = (in_value == '0);
    cls_in.radix   = clamp_radix(radix_r);
  end

  // Two-entry queue toward the back end.
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_value  = val_mem_r[rd_ptr_r];
  assign q_cls    = cls_mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, q_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      val_mem_r[wr_ptr_r] <= in_value;
      cls_mem_r[wr_ptr_r] <= cls_in;
    end
  end

endmodule

// ===== rtl/rdc_back.sv =====
module rdc_back import rdc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  logic [VALUE_BITS-1:0] q_value,
  input  rdc_cls_t              q_cls,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIGIT_W-1:0]    out_digit,
  output logic                  out_last_digit,
  output logic                  out_no_digits
);

  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t                state_r,    state_nxt;
  logic [VALUE_BITS-1:0] dvd_r,      dvd_nxt;
  logic [DIGIT_W-1:0]    rem_r,      rem_nxt;
  logic [RADIX_W-1:0]    radix_r,    radix_nxt;
  logic [BIT_W-1:0]      bit_cnt_r,  bit_cnt_nxt;
  logic [CNT_W-1:0]      cnt_r,      cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DIGIT_W-1:0]    digit_r,    digit_nxt;
  logic                  last_r,     last_nxt;
  logic                  nod_r,      nod_nxt;
  logic [DIGIT_W-1:0]    stack_r [MAX_DIGITS];
  logic                  out_free;
  logic [RADIX_W-1:0]    trial;
  logic                  ge;
  logic [DIGIT_W-1:0]    rem_step;
  logic [VALUE_BITS-1:0] dvd_step;
  logic                  digit_done;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CNT_W-1:0]      rd_pos;
  logic                  stack_we;

  assign out_free = !out_valid_r || !out_stall;

  // One restoring division step: the remainder stays below the radix.
  assign trial    = {rem_r, dvd_r[VALUE_BITS-1]};
  assign ge       = (trial >= radix_r);
  assign rem_step = ge ? DIGIT_W'(trial - radix_r) : trial[DIGIT_W-1:0];
  assign dvd_step = {dvd_r[VALUE_BITS-2:0], ge};

  assign digit_done = (bit_cnt_r == BIT_W'(VALUE_BITS - 1));
  assign cnt_inc    = cnt_r + 1'b1;
  assign rd_pos     = cnt_r - 1'b1;
  assign stack_we   = (state_r == S_DIV) && digit_done;

  assign q_pop = (state_r == S_IDLE) && q_valid && (!q_cls.is_zero || out_free);

  // Sequencer: take a request (a zero value is answered without division), divide digit by digit, then pop the stack.
  always_comb begin
    state_nxt     = state_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    bit_cnt_nxt   = bit_cnt_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    digit_nxt     = digit_r;
    last_nxt      = last_r;
    nod_nxt       = nod_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          if (q_cls.is_zero) begin
            out_valid_nxt = 1'b1;
            digit_nxt     = '0;
            last_nxt      = 1'b1;
            nod_nxt       = 1'b1;
          end else begin
            dvd_nxt     = q_value;
            rem_nxt     = '0;
            radix_nxt   = q_cls.radix;
            bit_cnt_nxt = '0;
            cnt_nxt     = '0;
            state_nxt   = S_DIV;
          end
        end
      end
      S_DIV: begin
        dvd_nxt     = dvd_step;
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (digit_done) begin
          cnt_nxt     = cnt_inc;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          if ((dvd_step == '0) || (cnt_inc >= CNT_W'(MAX_DIGITS))) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          digit_nxt     = stack_r[rd_pos[IDX_W-1:0]];
          last_nxt      = (cnt_r == CNT_W'(1));
          nod_nxt       = 1'b0;
          cnt_nxt       = rd_pos;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      cnt_r       <= cnt_nxt;
    end
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    digit_r <= digit_nxt;
    last_r  <= last_nxt;
    nod_r   <= nod_nxt;
  end

  // Digit stack, least significant digit at the bottom.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_r[cnt_r[IDX_W-1:0]] <= rem_step;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit      = digit_r;
  assign out_last_digit = last_r;
  assign out_no_digits  = nod_r;

endmodule

// ===== rtl/radix_digit_converter_core.sv =====
// Converts each request value to digits in the radix held in the configuration
// register (values below two act as two, above 256 as 256) and returns them most
// significant first, one result per digit, the final one marked by last_digit; a
// zero value gives a single result with digit 0 and no_digits set. A nonzero
// value is divided digit by digit in the one-bit-per-cycle restoring divider,
// each remainder being pushed on the digit stack, which is then popped to the
// output. A two-entry request queue lets new values be accepted while a
// conversion is running.
module radix_digit_converter_core import rdc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DIGIT_W-1:0]    out_digit,
  output logic                  out_last_digit,
  output logic                  out_no_digits,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [RADIX_W-1:0]    cfg_radix
);

  logic                  q_valid;
  logic [VALUE_BITS-1:0] q_value;
  rdc_cls_t              q_cls;
  logic                  q_pop;

  // Request intake, classification and queue.
  rdc_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_radix (cfg_radix),
    .q_valid   (q_valid),
    .q_value   (q_value),
    .q_cls     (q_cls),
    .q_pop     (q_pop)
  );

  // Division, digit stack and result output.
  rdc_back #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_value        (q_value),
    .q_cls          (q_cls),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit      (out_digit),
    .out_last_digit (out_last_digit),
    .out_no_digits  (out_no_digits)
  );

endmodule
